// ===== design/acm27_pkg.sv =====
// Shared types, constants and small mod-27 helper functions for the affine cipher block.
package acm27_pkg;

  localparam int unsigned AlphaSize = 27;
  localparam logic [4:0] GapIndex = 5'd14;
  localparam logic [7:0] CharA = 8'h61;
  localparam logic [7:0] CharN = 8'h6e;
  localparam logic [7:0] CharO = 8'h6f;
  localparam logic [7:0] CharZ = 8'h7a;
  localparam logic [7:0] CharGap = 8'h23;

  localparam logic [1:0] CfgMode = 2'd0;
  localparam logic [1:0] CfgKeyMult = 2'd1;
  localparam logic [1:0] CfgKeyAdd = 2'd2;

  // Key material derived from the configuration registers.
  typedef struct packed {
    logic       mode;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] ainv;
    logic       bad;
  } key_t;

  // Decoded input symbol.
  typedef struct packed {
    logic       ok;
    logic [4:0] idx;
  } sym_t;

  // Reduces a value below 54 to its residue modulo 27.
  function automatic logic [4:0] sub27(input logic [7:0] x);
    logic [7:0] r;
    begin
      r = (x >= 8'(AlphaSize)) ? (x - 8'(AlphaSize)) : x;
      return r[4:0];
    end
  endfunction

  // One folding step: 32 is 5 modulo 27, so x keeps its residue.
  function automatic logic [7:0] fold32(input logic [9:0] x);
    return (8'(x[9:5]) * 8'd5) + 8'(x[4:0]);
  endfunction

  // Inverse of a residue modulo 27, zero where none exists.
  function automatic logic [4:0] inv27(input logic [4:0] a);
    logic [4:0] r;
    begin
      case (a)
        5'd1: r = 5'd1;
        5'd2: r = 5'd14;
        5'd4: r = 5'd7;
        5'd5: r = 5'd11;
        5'd7: r = 5'd4;
        5'd8: r = 5'd17;
        5'd10: r = 5'd19;
        5'd11: r = 5'd5;
        5'd13: r = 5'd25;
        5'd14: r = 5'd2;
        5'd16: r = 5'd22;
        5'd17: r = 5'd8;
        5'd19: r = 5'd10;
        5'd20: r = 5'd23;
        5'd22: r = 5'd16;
        5'd23: r = 5'd20;
        5'd25: r = 5'd13;
        5'd26: r = 5'd26;
        default: r = 5'd0;
      endcase
      return r;
    end
  endfunction

  // Maps a byte to its alphabet index.
  function automatic sym_t sym_decode(input logic [7:0] c);
    sym_t s;
    logic [7:0] d;
    begin
      s.ok = 1'b0;
      s.idx = 5'd0;
      d = 8'd0;
      if (c >= CharA && c <= CharN) begin
        d = c - CharA;
        s.ok = 1'b1;
        s.idx = d[4:0];
      end else if (c == CharGap) begin
        s.ok = 1'b1;
        s.idx = GapIndex;
      end else if (c >= CharO && c <= CharZ) begin
        d = c - CharO + 8'(GapIndex) + 8'd1;
        s.ok = 1'b1;
        s.idx = d[4:0];
      end
      return s;
    end
  endfunction

  // Maps an alphabet index (0..26) back to its byte.
  function automatic logic [7:0] sym_encode(input logic [4:0] idx);
    logic [7:0] r;
    begin
      if (idx < GapIndex) begin
        r = CharA + 8'(idx);
      end else if (idx == GapIndex) begin
        r = CharGap;
      end else begin
        r = CharO + 8'(idx) - 8'(GapIndex) - 8'd1;
      end
      return r;
    end
  endfunction

endpackage

// ===== design/acm27_keys.sv =====
// Configuration registers and the key values derived from them.
module acm27_keys (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [4:0]           cfg_data_i,
  output logic                 cfg_ready_o,
  output acm27_pkg::key_t      key_o
);
  import acm27_pkg::*;

  logic       mode_q;
  logic [4:0] key_mult_q;
  logic [4:0] key_add_q;
  logic [4:0] a_red;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      key_mult_q <= 5'd1;
      key_add_q  <= 5'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMode:    mode_q     <= cfg_data_i[0];
        CfgKeyMult: key_mult_q <= cfg_data_i;
        CfgKeyAdd:  key_add_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign a_red = sub27({3'b000, key_mult_q});

  always_comb begin
    key_o.mode = mode_q;
    key_o.a    = a_red;
    key_o.b    = sub27({3'b000, key_add_q});
    key_o.ainv = inv27(a_red);
    key_o.bad  = (inv27(a_red) == 5'd0);
  end

endmodule

// ===== design/acm27_pipe.sv =====
// Four-stage cipher datapath: decode, multiply-add, fold, reduce and re-encode.
module acm27_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  acm27_pkg::key_t key_i,
  input  logic            in_valid_i,
  input  logic [7:0]      in_char_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output logic [7:0]      out_char_o,
  output logic            key_error_o,
  input  logic            out_stall_i
);
  import acm27_pkg::*;

  logic       v1_q, v2_q, v3_q, v4_q;
  logic       rdy1, rdy2, rdy3, rdy4;
  logic [7:0] c1_q, c2_q, c3_q, c4_q;
  logic       s1_q, s2_q, s3_q;
  logic [4:0] t1_q;
  logic [9:0] p2_q;
  logic [5:0] f3_q;
  logic       e4_q;

  sym_t       sym;
  logic [4:0] t_d;
  logic [4:0] mult;
  logic [4:0] addk;
  logic [9:0] p_d;
  logic [7:0] f_a;
  logic [7:0] f_b;
  logic [4:0] k_res;

  // A stage takes new data when it is empty or its contents move on.
  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  // Decrypt works as ainv * (j - b), so the key offset is removed here.
  always_comb begin
    sym = sym_decode(in_char_i);
    if (key_i.mode) begin
      t_d = sub27(8'(sym.idx) + 8'(AlphaSize) - 8'(key_i.b));
    end else begin
      t_d = sym.idx;
    end
  end

  assign mult = key_i.mode ? key_i.ainv : key_i.a;
  assign addk = key_i.mode ? 5'd0 : key_i.b;
  assign p_d  = (10'(mult) * 10'(t1_q)) + 10'(addk);

  assign f_a = fold32(p2_q);
  assign f_b = fold32({2'b00, f_a});
  assign k_res = sub27({2'b00, f3_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      c1_q <= in_char_i;
      s1_q <= sym.ok && !key_i.bad;
      t1_q <= t_d;
    end
    if (rdy2) begin
      c2_q <= c1_q;
      s2_q <= s1_q;
      p2_q <= p_d;
    end
    if (rdy3) begin
      c3_q <= c2_q;
      s3_q <= s2_q;
      f3_q <= f_b[5:0];
    end
    if (rdy4) begin
      c4_q <= s3_q ? sym_encode(k_res) : c3_q;
      e4_q <= key_i.bad;
    end
  end

  assign out_valid_o = v4_q;
  assign out_char_o  = c4_q;
  assign key_error_o = e4_q;

endmodule

// ===== design/affine_cipher_mod27.sv =====
// Affine cipher over a 27-symbol alphabet (a..n, '#', o..z): top level.
// Takes one byte per cycle while in_stall_o is low and returns one byte per byte
// through four pipeline registers (decode, multiply-add, modulo fold, reduce and
// re-encode). Bytes outside the alphabet pass through unchanged. When key_mult has
// no inverse modulo 27, key_error_o is high and every byte passes through.
// Configuration (index 0 mode, 1 key_mult, 2 key_add) is always accepted and should
// be written only while no byte is in flight.
module affine_cipher_mod27 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_index_i,
  input  logic [4:0] cfg_data_i,
  output logic       cfg_ready_o,
  input  logic       in_valid_i,
  input  logic [7:0] in_char_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output logic [7:0] out_char_o,
  output logic       key_error_o,
  input  logic       out_stall_i
);
  import acm27_pkg::*;

  key_t key;

  acm27_keys u_keys (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .key_o       (key)
  );

  acm27_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key),
    .in_valid_i  (in_valid_i),
    .in_char_i   (in_char_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .key_error_o (key_error_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== design/acm27_checker.sv =====
// Port-level assertions for the affine cipher block and their binding.
module acm27_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_valid_i,
  input logic [1:0] cfg_index_i,
  input logic [4:0] cfg_data_i,
  input logic       cfg_ready_o,
  input logic       in_valid_i,
  input logic [7:0] in_char_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic [7:0] out_char_o,
  input logic       key_error_o,
  input logic       out_stall_i
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o) && $stable(key_error_o))
    else $error("stalled result changed");

  // The input is only held off when a finished result is blocked at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output can drain");

  // With no output stall, an accepted item comes through to out_valid_o.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("item did not reach the output in four cycles");

  // Configuration writes are never held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind affine_cipher_mod27 acm27_checker u_acm27_checker (.*);
